@@ rtl/fcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  // Image layout
  localparam int          HEADER_BYTES = 8;
  localparam logic [15:0] HDR_LEN      = 16'(HEADER_BYTES);

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Stream widths
  localparam int IN_W  = 40;
  localparam int OUT_W = 88;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_OVERRUN = 2'd1,
    ERR_SHORT   = 2'd2
  } img_err_t;

  // Advance the CRC by one byte, one bit step per polynomial shift
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/firmware_chunk_receiver_crc32.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Firmware chunk receiver with CRC-32 check. Takes one image byte per request,
// tagged with its chunk number and a chunk-end mark (tlast); bytes of any chunk
// other than the expected one are dropped. The total size is latched from the
// first byte of chunk zero; image bytes 0-1 are the little-endian length and
// bytes 2-5 the little-endian CRC; bytes from offset 8 on feed a reflected
// CRC-32. Each input request produces exactly one result request carrying the
// status after that byte. Throughput is one byte per clock unless the output
// stalls; the result appears in the cycle after the byte is accepted, as the
// unrolled 8-bit CRC update is combinational between the state registers and
// the result register. The output register decouples the sides: a new byte
// is taken whenever the result register is empty or being drained. Once
// complete (or in error) all further bytes are ignored until reset.
module firmware_chunk_receiver_crc32 import fcr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // s_tdata: chunk_number[15:0], image_size[31:16], data_byte[39:32]
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tlast,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // m_tdata: accepted[0], complete[1], crc_match[2], header_crc[34:3],
  //          computed_crc[66:35], header_length[82:67], image_error[84:83], zero[87:85]
  output logic [OUT_W-1:0]      m_tdata
);

  logic [15:0] chunk_number;
  logic [15:0] image_size;
  logic [7:0]  data_byte;

  // Receiver state
  logic [15:0] expected_chunk, expected_chunk_next;
  logic [15:0] received_count, received_count_next;
  logic [15:0] total_bytes,    total_bytes_next;
  logic        total_latched,  total_latched_next;
  logic [31:0] crc_register,   crc_register_next;
  logic [31:0] header_crc,     header_crc_next;
  logic [15:0] header_length,  header_length_next;
  logic        done_flag,      done_flag_next;
  img_err_t    image_error,    image_error_next;

  logic        accepted_next;
  logic        crc_match_next;
  logic [31:0] computed_crc_next;
  logic        in_fire;

  assign chunk_number = s_tdata[15:0];
  assign image_size   = s_tdata[31:16];
  assign data_byte    = s_tdata[39:32];

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // Compute state after this byte
  always_comb begin
    expected_chunk_next = expected_chunk;
    received_count_next = received_count;
    total_bytes_next    = total_bytes;
    total_latched_next  = total_latched;
    crc_register_next   = crc_register;
    header_crc_next     = header_crc;
    header_length_next  = header_length;
    done_flag_next      = done_flag;
    image_error_next    = image_error;
    accepted_next       = 1'b0;
    if (!done_flag) begin
      if (chunk_number == 16'h0 && !total_latched) begin
        total_bytes_next   = image_size;
        total_latched_next = 1'b1;
      end
      if (chunk_number == expected_chunk) begin
        if (received_count >= total_bytes_next) begin
          image_error_next = ERR_OVERRUN;
          done_flag_next   = 1'b1;
        end else begin
          case (received_count)
            16'd0: header_length_next[7:0]  = data_byte;
            16'd1: header_length_next[15:8] = data_byte;
            16'd2: header_crc_next[7:0]     = data_byte;
            16'd3: header_crc_next[15:8]    = data_byte;
            16'd4: header_crc_next[23:16]   = data_byte;
            16'd5: header_crc_next[31:24]   = data_byte;
            default: ;
          endcase
          if (received_count >= HDR_LEN) begin
            crc_register_next = crc_byte(crc_register, data_byte);
          end
          received_count_next = received_count + 16'd1;
          if (s_tlast) begin
            expected_chunk_next = expected_chunk + 16'd1;
          end
          accepted_next = 1'b1;
        end
      end
      if (!done_flag_next && total_latched_next &&
          received_count_next == total_bytes_next && received_count_next != 16'h0) begin
        done_flag_next = 1'b1;
        if (total_bytes_next < HDR_LEN) begin
          image_error_next = ERR_SHORT;
        end
      end
    end
    computed_crc_next = crc_register_next ^ CRC_ONES;
    crc_match_next    = done_flag_next && (image_error_next == ERR_NONE) &&
                        (computed_crc_next == header_crc_next);
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_chunk <= 16'h0;
      received_count <= 16'h0;
      total_bytes    <= 16'h0;
      total_latched  <= 1'b0;
      crc_register   <= CRC_ONES;
      header_crc     <= 32'h0;
      header_length  <= 16'h0;
      done_flag      <= 1'b0;
      image_error    <= ERR_NONE;
    end else if (in_fire) begin
      expected_chunk <= expected_chunk_next;
      received_count <= received_count_next;
      total_bytes    <= total_bytes_next;
      total_latched  <= total_latched_next;
      crc_register   <= crc_register_next;
      header_crc     <= header_crc_next;
      header_length  <= header_length_next;
      done_flag      <= done_flag_next;
      image_error    <= image_error_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {3'b000, image_error_next, header_length_next, computed_crc_next,
                  header_crc_next, crc_match_next, done_flag_next, accepted_next};
    end
  end

  // Checks
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("done flag dropped before reset");

  a_err_implies_done: assert property (@(posedge clk) disable iff (rst)
    (image_error != ERR_NONE) |-> done_flag)
    else $error("image error set while not done");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    total_latched |-> (received_count <= total_bytes))
    else $error("received count past total");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_tvalid)
    else $error("accepted request produced no result");

  a_done_frozen: assert property (@(posedge clk) disable iff (rst)
    (done_flag && in_fire) |=> $stable(received_count) && $stable(crc_register))
    else $error("state changed after completion");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import fcr_pkg::*;

  localparam int IMG_MAX        = 2048;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 150;
  localparam int TAIL_ITEMS     = 60;
  localparam int CALM_BYTES     = 200;
  localparam int STIM_ROWS      = 19;
  localparam int ITEM_TOTAL     = 1950;

  typedef enum int {
    SCN_NORMAL,
    SCN_SHORT,
    SCN_ZERO
  } scenario_t;

  typedef struct packed {
    logic        accepted;
    logic        complete;
    logic        crc_match;
    logic [31:0] header_crc;
    logic [31:0] computed_crc;
    logic [15:0] header_length;
    img_err_t    image_error;
  } status_t;

  // img: take chunk number and data from the image under construction
  // at_reset: the status must still read as right after reset
  typedef struct packed {
    logic        img;
    logic [15:0] chunk;
    logic [15:0] img_size;
    logic [7:0]  data;
    logic        last;
    logic        at_reset;
  } row_t;

  localparam status_t RESET_STATUS = '{1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 16'h0, ERR_NONE};

  localparam row_t STIM [0:STIM_ROWS-1] = '{
    // chunks out of order before any chunk zero arrives
    '{1'b0, 16'h0003, 16'hFFFF, 8'hFF, 1'b1, 1'b1},
    '{1'b0, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 1'b1},
    // first chunk-zero byte latches the total
    '{1'b1, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 1'b0},
    // next chunk too early
    '{1'b0, 16'h0001, 16'h1234, 8'h5A, 1'b1, 1'b0},
    '{1'b1, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b0, 1'b0},
    // first payload bytes are 0x00 and 0xFF
    '{1'b1, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b1, 1'b0},
    // chunk zero resent: total must stay latched
    '{1'b0, 16'h0000, 16'h0000, 8'hA5, 1'b1, 1'b0},
    '{1'b1, 16'h0000, 16'hAAAA, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'h8000, 16'hAAAA, 8'h55, 1'b0, 1'b0},
    '{1'b1, 16'h0000, 16'h5555, 8'h00, 1'b1, 1'b0},
    '{1'b1, 16'h0000, 16'hFFFF, 8'h00, 1'b1, 1'b0},
    // chunk already finished
    '{1'b0, 16'h0002, 16'h5555, 8'hC3, 1'b0, 1'b0}
  };

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // s_tdata: chunk_number[15:0], image_size[31:16], data_byte[39:32]
  logic [IN_W-1:0]  s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  // m_tdata: accepted[0], complete[1], crc_match[2], header_crc[34:3],
  //          computed_crc[66:35], header_length[82:67], image_error[84:83]
  logic [OUT_W-1:0] m_tdata;

  // Predicted receiver state
  logic [15:0] want_chunk  = '0;
  logic [15:0] rx_count    = '0;
  logic [15:0] total_bytes = '0;
  logic        total_seen  = 1'b0;
  logic [31:0] crc_reg     = CRC_ONES;
  logic [31:0] hdr_crc     = '0;
  logic [15:0] hdr_len     = '0;
  logic        img_done    = 1'b0;
  img_err_t    img_err     = ERR_NONE;

  // Image under construction on the sender side
  logic [7:0]  image [0:IMG_MAX-1];
  logic [15:0] total_size;
  logic [15:0] gen_chunk = '0;
  int          gen_pos   = 0;
  bit          calm      = 1'b0;
  logic        at_reset_tag;
  int          sent_items = 0;

  status_t     pending_status [$];
  int          mismatches   = 0;
  int          bytes_taken  = 0;
  int          quiet_cycles = 0;

  firmware_chunk_receiver_crc32 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shift one byte into the reflected CRC, least significant bit first
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int          i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  // Advance the predicted receiver by one accepted request
  task automatic advance_image(input logic [15:0] chunk, input logic [15:0] img_size,
                               input logic [7:0] b, input logic last,
                               output status_t st);
    logic        took;
    logic [31:0] crc_out;
    took = 1'b0;
    if (!img_done) begin
      if (chunk == 16'h0000 && !total_seen) begin
        total_bytes = img_size;
        total_seen  = 1'b1;
      end
      if (chunk == want_chunk) begin
        if (rx_count >= total_bytes) begin
          img_err  = ERR_OVERRUN;
          img_done = 1'b1;
        end else begin
          if (rx_count == 16'd0) hdr_len[7:0] = b;
          else if (rx_count == 16'd1) hdr_len[15:8] = b;
          else if (rx_count <= 16'd5) hdr_crc[(int'(rx_count) - 2) * 8 +: 8] = b;
          if (rx_count >= HDR_LEN) crc_reg = crc_step(crc_reg, b);
          rx_count = rx_count + 16'd1;
          if (last) want_chunk = want_chunk + 16'd1;
          took = 1'b1;
        end
      end
      if (!img_done && total_seen && rx_count == total_bytes && rx_count != 16'd0) begin
        img_done = 1'b1;
        if (total_bytes < HDR_LEN) img_err = ERR_SHORT;
      end
    end
    crc_out          = crc_reg ^ CRC_ONES;
    st.accepted      = took;
    st.complete      = img_done;
    st.crc_match     = img_done && img_err == ERR_NONE && crc_out == hdr_crc;
    st.header_crc    = hdr_crc;
    st.computed_crc  = crc_out;
    st.header_length = hdr_len;
    st.image_error   = img_err;
  endtask

  // Offer one request and hold it until the block takes it
  task automatic drive_item(input logic [15:0] chunk, input logic [15:0] img_size,
                            input logic [7:0] b, input logic last, input logic at_reset);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid     <= 1'b1;
    s_tdata      <= {b, img_size, chunk};
    s_tlast      <= last;
    at_reset_tag <= at_reset;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  // Send the next image byte in order
  task automatic send_image_byte(input logic last, input logic [15:0] size_hint);
    logic [15:0] img_size;
    img_size = (gen_pos == 0) ? total_size : size_hint;
    drive_item(gen_chunk, img_size, image[gen_pos], last, 1'b0);
    gen_pos++;
    if (last) gen_chunk = gen_chunk + 16'd1;
  endtask

  // Send a byte tagged with a chunk number other than the expected one
  task automatic send_noise();
    logic [15:0] n;
    case ($urandom_range(0, 3))
      0: n = 16'($urandom);
      1: n = gen_chunk - 16'd1;
      2: n = gen_chunk + 16'd1;
      default: n = 16'h0000;
    endcase
    if (n == gen_chunk) n = n ^ 16'h0001;
    drive_item(n, 16'($urandom), 8'($urandom), 1'($urandom), 1'b0);
  endtask

  // Sender: build the image, then directed rows, random stream and tail
  initial begin
    scenario_t   scn;
    logic [31:0] img_crc;
    logic [15:0] hdr;
    int          i;
    int          chunk_left;
    int          tail_sent;
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tlast      <= 1'b0;
    at_reset_tag <= 1'b0;

    case ($urandom_range(0, 9))
      0: scn = SCN_ZERO;
      1: scn = SCN_SHORT;
      default: scn = SCN_NORMAL;
    endcase
    case (scn)
      SCN_ZERO:  total_size = 16'd0;
      SCN_SHORT: total_size = 16'($urandom_range(1, HEADER_BYTES - 1));
      default:   total_size = 16'($urandom_range(1650, 1780));
    endcase

    for (i = 0; i < IMG_MAX; i++) image[i] = 8'($urandom);
    hdr = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    image[0] = hdr[7:0];
    image[1] = hdr[15:8];
    image[HEADER_BYTES]     = 8'h00;
    image[HEADER_BYTES + 1] = 8'hFF;
    img_crc = CRC_ONES;
    for (i = HEADER_BYTES; i < int'(total_size); i++) img_crc = crc_step(img_crc, image[i]);
    img_crc = img_crc ^ CRC_ONES;
    // corrupt the header CRC now and then
    if ($urandom_range(0, 3) == 0) img_crc = img_crc ^ (32'h1 << $urandom_range(0, 31));
    for (i = 0; i < 4; i++) image[2 + i] = img_crc[i * 8 +: 8];

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < STIM_ROWS; i++) begin
      if (STIM[i].img) send_image_byte(STIM[i].last, STIM[i].img_size);
      else drive_item(STIM[i].chunk, STIM[i].img_size, STIM[i].data, STIM[i].last,
                      STIM[i].at_reset);
    end

    // Random chunks of 1 to 40 bytes with stray requests mixed in
    chunk_left = 0;
    while (gen_pos < int'(total_size)) begin
      if (gen_pos + CALM_BYTES >= int'(total_size)) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        if (chunk_left == 0) chunk_left = $urandom_range(1, 40);
        chunk_left--;
        send_image_byte(chunk_left == 0 || gen_pos == int'(total_size) - 1, 16'($urandom));
        if (gen_pos == int'(total_size)) chunk_left = 0;
      end
    end

    // Requests after completion must leave the status untouched; a short image
    // is padded out to the full request count here
    tail_sent = 0;
    while (tail_sent < TAIL_ITEMS || sent_items < ITEM_TOTAL) begin
      if (sent_items + CALM_BYTES >= ITEM_TOTAL) calm = 1'b1;
      if ($urandom_range(0, 1) == 1) send_noise();
      else send_image_byte(1'($urandom), 16'($urandom));
      tail_sent++;
    end
    s_tvalid <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back up the input
  initial begin
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!held && bytes_taken >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        advance_image(s_tdata[15:0], s_tdata[31:16], s_tdata[39:32], s_tlast, want);
        if (at_reset_tag) want = RESET_STATUS;
        pending_status.push_back(want);
        bytes_taken <= bytes_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        got.accepted      = m_tdata[0];
        got.complete      = m_tdata[1];
        got.crc_match     = m_tdata[2];
        got.header_crc    = m_tdata[34:3];
        got.computed_crc  = m_tdata[66:35];
        got.header_length = m_tdata[82:67];
        got.image_error   = img_err_t'(m_tdata[84:83]);
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = pending_status.pop_front();
          if (got.accepted !== want.accepted || got.complete !== want.complete ||
              got.crc_match !== want.crc_match || got.header_crc !== want.header_crc ||
              got.computed_crc !== want.computed_crc ||
              got.header_length !== want.header_length ||
              got.image_error !== want.image_error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp acc=%0b cmp=%0b match=%0b hcrc=%h crc=%h len=%h err=%0d",
                       want.accepted, want.complete, want.crc_match, want.header_crc,
                       want.computed_crc, want.header_length, want.image_error);
              $display("          got acc=%0b cmp=%0b match=%0b hcrc=%h crc=%h len=%h err=%0d",
                       got.accepted, got.complete, got.crc_match, got.header_crc,
                       got.computed_crc, got.header_length, got.image_error);
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stop a run that no longer moves any request
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
